// ===== design/isb_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// indexed stack buffer. No dependencies.
package isb_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // fixed field widths
   localparam int MODE_W      = 2;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 5;

   // compare width: holds index, count and pointer plus two without wrap
   localparam int CMP_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

   // request beat layout
   localparam int REQ_MODE_LSB  = 0;
   localparam int REQ_VALUE_LSB = REQ_MODE_LSB + MODE_W;
   localparam int REQ_INDEX_LSB = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_TDATA_W   = ((REQ_INDEX_LSB + INDEX_W + 7) / 8) * 8;

   // response beat layout
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_WORD_LSB   = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_COUNT_LSB  = RSP_WORD_LSB + VALUE_W;
   localparam int RSP_USED_W     = RSP_COUNT_LSB + COUNT_OUT_W;
   localparam int RSP_TDATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH    = 2'd0,
      MODE_POP     = 2'd1,
      MODE_REMOVE  = 2'd2,
      MODE_REVERSE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_EMPTY = 3'd2,
      ST_NULL  = 3'd3,
      ST_RANGE = 3'd4
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch request beat
      logic exec;        // status known, start the operation
      logic pop_take;    // capture popped word
      logic rm_take;     // capture removed word, start shift
      logic shift_step;  // move one entry down
      logic rev_low;     // write low side of a swap
      logic rev_high;    // write high side of a swap, read next pair
      logic finish;      // load response, commit count
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      mode_type mode;
      logic     ok;
      logic     short_list;
      logic     rm_more;
      logic     shift_more;
      logic     rev_more;
   } stat_type;

endpackage

// ===== design/isb_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module isb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== design/isb_dp.sv =====
// Datapath: request latch, count, entry RAM addressing, shift/swap pointers
// and response register. Depends on isb_pkg and isb_ram.
module isb_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [isb_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  isb_pkg::cmd_type               cmd,
   output isb_pkg::stat_type              stat,
   output logic [isb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW  = isb_pkg::ADDR_W;
   localparam int CW  = isb_pkg::CNT_W;
   localparam int XW  = isb_pkg::CMP_W;
   localparam int WW  = isb_pkg::WORD_WIDTH;

   isb_pkg::mode_type               mode_ff, mode_in;
   logic [WW-1:0]                   value_ff, value_in;
   logic [isb_pkg::INDEX_W-1:0]     index_ff, index_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [WW-1:0]                   word_ff, word_in;
   logic [WW-1:0]                   temp_ff, temp_in;
   logic [AW-1:0]                   lo_ff, lo_in;
   logic [AW-1:0]                   hi_ff, hi_in;
   logic [isb_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   isb_pkg::status_type status;
   logic [CW-1:0]       count_next;
   logic [AW-1:0]       last_addr;
   logic [XW-1:0]       index_x, count_x, lo_x, hi_x;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [WW-1:0] wr_data, rd_data_a, rd_data_b;

   isb_ram #(
      .WIDTH (WW),
      .DEPTH (isb_pkg::DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign index_x   = XW'(index_ff);
   assign count_x   = XW'(count_ff);
   assign lo_x      = XW'(lo_ff);
   assign hi_x      = XW'(hi_ff);
   assign last_addr = AW'(count_ff - CW'(1));

   // status is stable from capture to finish: fields latched, count held
   always_comb begin
      status = isb_pkg::ST_OK;
      unique case (mode_ff)
         isb_pkg::MODE_PUSH: begin
            if (value_ff == '0) begin
               status = isb_pkg::ST_NULL;
            end else if (count_ff == CW'(isb_pkg::DEPTH)) begin
               status = isb_pkg::ST_FULL;
            end
         end
         isb_pkg::MODE_POP: begin
            if (count_ff == '0) begin
               status = isb_pkg::ST_EMPTY;
            end
         end
         isb_pkg::MODE_REMOVE: begin
            if (count_ff == '0) begin
               status = isb_pkg::ST_EMPTY;
            end else if (index_x >= count_x) begin
               status = isb_pkg::ST_RANGE;
            end
         end
         isb_pkg::MODE_REVERSE: begin
            status = isb_pkg::ST_OK;
         end
         default: begin
            status = isb_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      count_next = count_ff;
      if (status == isb_pkg::ST_OK) begin
         case (mode_ff) inside
            isb_pkg::MODE_PUSH:                         count_next = count_ff + CW'(1);
            isb_pkg::MODE_POP, isb_pkg::MODE_REMOVE:    count_next = count_ff - CW'(1);
            default:                                    count_next = count_ff;
         endcase
      end
   end

   assign stat.mode       = mode_ff;
   assign stat.ok         = (status == isb_pkg::ST_OK);
   assign stat.short_list = (count_ff < CW'(2));
   assign stat.rm_more    = ((index_x + XW'(1)) < count_x);
   assign stat.shift_more = ((lo_x + XW'(2)) < count_x);
   assign stat.rev_more   = ((lo_x + XW'(2)) < hi_x);

   always_comb begin
      mode_in     = mode_ff;
      value_in    = value_ff;
      index_in    = index_ff;
      count_in    = count_ff;
      word_in     = word_ff;
      temp_in     = temp_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      rsp_data_in = rsp_data_ff;
      wr_en       = 1'b0;
      wr_addr     = lo_ff;
      wr_data     = rd_data_b;
      rd_addr_a   = lo_ff;
      rd_addr_b   = hi_ff;

      if (cmd.capture) begin
         mode_in  = isb_pkg::mode_type'(req_tdata[isb_pkg::REQ_MODE_LSB +: isb_pkg::MODE_W]);
         value_in = WW'(req_tdata[isb_pkg::REQ_VALUE_LSB +: isb_pkg::VALUE_W]);
         index_in = req_tdata[isb_pkg::REQ_INDEX_LSB +: isb_pkg::INDEX_W];
         word_in  = '0;
      end

      if (cmd.exec) begin
         case (mode_ff)
            isb_pkg::MODE_PUSH: begin
               wr_en   = stat.ok;
               wr_addr = AW'(count_ff);
               wr_data = value_ff;
            end
            isb_pkg::MODE_POP: begin
               rd_addr_a = last_addr;
            end
            isb_pkg::MODE_REMOVE: begin
               rd_addr_a = AW'(index_ff);
            end
            default: begin
               rd_addr_a = '0;
               rd_addr_b = last_addr;
               lo_in     = '0;
               hi_in     = last_addr;
            end
         endcase
      end

      if (cmd.pop_take) begin
         word_in = rd_data_a;
      end

      // fetch the entry above the hole; the shift writes it one place down
      if (cmd.rm_take) begin
         word_in   = rd_data_a;
         lo_in     = AW'(index_ff);
         rd_addr_a = AW'(index_x + XW'(1));
      end

      if (cmd.shift_step) begin
         wr_en     = 1'b1;
         wr_addr   = lo_ff;
         wr_data   = rd_data_a;
         rd_addr_a = AW'(lo_x + XW'(2));
         lo_in     = lo_ff + AW'(1);
      end

      if (cmd.rev_low) begin
         wr_en   = 1'b1;
         wr_addr = lo_ff;
         wr_data = rd_data_b;
         temp_in = rd_data_a;
      end

      // next pair is read while the high side is written
      if (cmd.rev_high) begin
         wr_en     = 1'b1;
         wr_addr   = hi_ff;
         wr_data   = temp_ff;
         rd_addr_a = lo_ff + AW'(1);
         rd_addr_b = hi_ff - AW'(1);
         lo_in     = lo_ff + AW'(1);
         hi_in     = hi_ff - AW'(1);
      end

      if (cmd.finish) begin
         count_in    = count_next;
         rsp_data_in = '0;
         rsp_data_in[isb_pkg::RSP_STATUS_LSB +: isb_pkg::STATUS_W] = status;
         rsp_data_in[isb_pkg::RSP_WORD_LSB +: isb_pkg::VALUE_W] =
            isb_pkg::VALUE_W'(word_ff);
         rsp_data_in[isb_pkg::RSP_COUNT_LSB +: isb_pkg::COUNT_OUT_W] =
            isb_pkg::COUNT_OUT_W'(count_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      value_ff    <= value_in;
      index_ff    <= index_in;
      word_ff     <= word_in;
      temp_ff     <= temp_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== design/isb_ctrl.sv =====
// Controller: one-hot sequencer for the four operations and the response
// valid flag. Depends on isb_pkg.
module isb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  isb_pkg::stat_type stat,
   output isb_pkg::cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_EXEC     = 8'b0000_0010,
      S_POP_WAIT = 8'b0000_0100,
      S_RM_WORD  = 8'b0000_1000,
      S_SHIFT    = 8'b0001_0000,
      S_REV_LOW  = 8'b0010_0000,
      S_REV_HIGH = 8'b0100_0000,
      S_FINISH   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (!stat.ok) begin
               state_in = S_FINISH;
            end else begin
               unique case (stat.mode)
                  isb_pkg::MODE_PUSH:   state_in = S_FINISH;
                  isb_pkg::MODE_POP:    state_in = S_POP_WAIT;
                  isb_pkg::MODE_REMOVE: state_in = S_RM_WORD;
                  default:              state_in = stat.short_list ? S_FINISH : S_REV_LOW;
               endcase
            end
         end
         S_POP_WAIT: begin
            cmd.pop_take = 1'b1;
            state_in     = S_FINISH;
         end
         S_RM_WORD: begin
            cmd.rm_take = 1'b1;
            state_in    = stat.rm_more ? S_SHIFT : S_FINISH;
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            state_in       = stat.shift_more ? S_SHIFT : S_FINISH;
         end
         S_REV_LOW: begin
            cmd.rev_low = 1'b1;
            state_in    = S_REV_HIGH;
         end
         S_REV_HIGH: begin
            cmd.rev_high = 1'b1;
            state_in     = stat.rev_more ? S_REV_LOW : S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free or being drained
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/indexed_stack_buffer.sv =====
// Top level of the indexed stack buffer: controller plus datapath.
// Depends on isb_pkg, isb_ctrl, isb_dp (and isb_ram through isb_dp).
//
//  channel | dir | beat contents (low bit up)
//  --------+-----+-----------------------------------------------------
//  req     | in  | mode[1:0], value[33:2], index[37:34], zero [39:38]
//  rsp     | out | status[2:0], word_out[34:3], count_now[39:35]
//
// One request at a time. After the accept come exec, then a read wait for pop,
// a read and a shift step per entry above the index for remove, or a low and
// a high write per swapped pair for reverse, then finish, which loads the
// response; the single RAM write port sets how long remove and reverse take.
// The next request is taken the cycle after the response is loaded, even
// while it waits on rsp_tready. A stalled response holds the sequencer in its
// last step. Reset clears the count; entry contents are not cleared.
module indexed_stack_buffer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // mode[1:0], value[33:2], index[37:34], zero pad
   input  logic [isb_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], word_out[34:3], count_now[39:35]
   output logic [isb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   isb_pkg::cmd_type  cmd;
   isb_pkg::stat_type stat;

   isb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   isb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== design/isb_checker.sv =====
// Port-level checks for indexed_stack_buffer, bound to the top level.
// Depends on isb_pkg.
module isb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [isb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic [isb_pkg::STATUS_W-1:0]    rsp_status;
   logic [isb_pkg::VALUE_W-1:0]     rsp_word;
   logic [isb_pkg::COUNT_OUT_W-1:0] rsp_count;

   assign rsp_status = rsp_tdata[isb_pkg::RSP_STATUS_LSB +: isb_pkg::STATUS_W];
   assign rsp_word   = rsp_tdata[isb_pkg::RSP_WORD_LSB +: isb_pkg::VALUE_W];
   assign rsp_count  = rsp_tdata[isb_pkg::RSP_COUNT_LSB +: isb_pkg::COUNT_OUT_W];

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // one request in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= isb_pkg::COUNT_OUT_W'(isb_pkg::DEPTH))
      else $error("count beyond capacity");

   // failed requests return no word
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != isb_pkg::ST_OK) |-> rsp_word == '0)
      else $error("nonzero word on failed request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_status <= isb_pkg::ST_RANGE)
      else $error("undefined status code");

endmodule

bind indexed_stack_buffer isb_checker u_isb_checker (.*);

// ===== test/indexed_stack_buffer_tb.sv =====
// Self-checking testbench for indexed_stack_buffer: directed table then random
// push/pop/remove/reverse traffic, checked beat by beat against a shadow stack.
// Depends on isb_pkg and the indexed_stack_buffer RTL.
module indexed_stack_buffer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS    = 1100;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int HOLD_OFF_AT     = 300;
   localparam int TAIL_CYCLES     = isb_pkg::DEPTH + 12;
   localparam int REPORT_LIMIT    = 10;
   localparam int PLAN_ROWS       = 24;

   typedef struct packed {
      isb_pkg::status_type             status;
      logic [isb_pkg::VALUE_W-1:0]     word;
      logic [isb_pkg::COUNT_OUT_W-1:0] count;
   } reply_type;

   typedef struct packed {
      isb_pkg::mode_type               mode;
      logic [isb_pkg::VALUE_W-1:0]     value;
      logic [isb_pkg::INDEX_W-1:0]     index;
      logic [4:0]                      reps;    // row repeats with value + k
      logic                            pinned;  // expected reply typed in below
      isb_pkg::status_type             status;
      logic [isb_pkg::VALUE_W-1:0]     word;
      logic [isb_pkg::COUNT_OUT_W-1:0] count;
   } plan_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [isb_pkg::REQ_TDATA_W-1:0] req_tdata;   // mode, value, index, zero pad
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [isb_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // status, word_out, count_now, zero pad

   // shadow copy of the stack
   logic [isb_pkg::WORD_WIDTH-1:0] shadow_words [isb_pkg::DEPTH];
   int                             shadow_count;

   reply_type pending_replies [$];
   int        mismatch_count;
   int        replies_seen;
   int        idle_cycles;
   bit        pin_active;
   reply_type pin_reply;
   bit        steady_sender;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{isb_pkg::MODE_POP,     0,             0,  1,  1, isb_pkg::ST_EMPTY, 0, 0},
      '{isb_pkg::MODE_REMOVE,  0,             0,  1,  1, isb_pkg::ST_EMPTY, 0, 0},
      '{isb_pkg::MODE_REVERSE, 32'hFFFF_FFFF, 15, 1,  1, isb_pkg::ST_OK,    0, 0},
      '{isb_pkg::MODE_PUSH,    0,             0,  1,  1, isb_pkg::ST_NULL,  0, 0},
      '{isb_pkg::MODE_PUSH,    32'hFFFF_FFFF, 0,  1,  1, isb_pkg::ST_OK,    0, 1},
      '{isb_pkg::MODE_REVERSE, 0,             0,  1,  1, isb_pkg::ST_OK,    0, 1},
      '{isb_pkg::MODE_REMOVE,  0,             1,  1,  1, isb_pkg::ST_RANGE, 0, 1},
      '{isb_pkg::MODE_REMOVE,  0,             15, 1,  1, isb_pkg::ST_RANGE, 0, 1},
      '{isb_pkg::MODE_PUSH,    1,             15, 1,  1, isb_pkg::ST_OK,    0, 2},
      '{isb_pkg::MODE_REVERSE, 0,             0,  1,  1, isb_pkg::ST_OK,    0, 2},
      '{isb_pkg::MODE_POP,     0,             0,  1,  0, isb_pkg::ST_OK,    0, 0},
      '{isb_pkg::MODE_PUSH,    32'h8000_0000, 0,  15, 0, isb_pkg::ST_OK,    0, 0},
      '{isb_pkg::MODE_PUSH,    32'h5555_5555, 0,  1,  1, isb_pkg::ST_FULL,  0, 16},
      '{isb_pkg::MODE_PUSH,    0,             0,  1,  1, isb_pkg::ST_NULL,  0, 16},
      '{isb_pkg::MODE_REVERSE, 0,             0,  1,  1, isb_pkg::ST_OK,    0, 16},
      '{isb_pkg::MODE_REMOVE,  0,             15, 1,  0, isb_pkg::ST_OK,    0, 0},
      '{isb_pkg::MODE_REMOVE,  0,             0,  1,  0, isb_pkg::ST_OK,    0, 0},
      '{isb_pkg::MODE_REMOVE,  0,             14, 1,  1, isb_pkg::ST_RANGE, 0, 14},
      '{isb_pkg::MODE_REMOVE,  0,             7,  1,  0, isb_pkg::ST_OK,    0, 0},
      '{isb_pkg::MODE_POP,     0,             0,  1,  0, isb_pkg::ST_OK,    0, 0},
      '{isb_pkg::MODE_REVERSE, 0,             0,  1,  1, isb_pkg::ST_OK,    0, 12},
      '{isb_pkg::MODE_POP,     0,             0,  1,  0, isb_pkg::ST_OK,    0, 0},
      '{isb_pkg::MODE_PUSH,    32'hFFFF_FFFF, 3,  1,  1, isb_pkg::ST_OK,    0, 12},
      '{isb_pkg::MODE_REMOVE,  0,             11, 1,  0, isb_pkg::ST_OK,    0, 0}
   };

   indexed_stack_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Applies one request to the shadow stack and returns the reply it gives.
   function automatic reply_type stack_apply(isb_pkg::mode_type m,
                                             logic [isb_pkg::VALUE_W-1:0] v,
                                             logic [isb_pkg::INDEX_W-1:0] idx);
      reply_type                      r;
      logic [isb_pkg::WORD_WIDTH-1:0] w;
      logic [isb_pkg::WORD_WIDTH-1:0] swap_word;
      int                             n;
      int                             i;
      r = '{isb_pkg::ST_OK, '0, '0};
      w = v[isb_pkg::WORD_WIDTH-1:0];
      n = shadow_count;
      case (m)
         isb_pkg::MODE_PUSH: begin
            // null check wins over full
            if (w == '0) r.status = isb_pkg::ST_NULL;
            else if (n >= isb_pkg::DEPTH) r.status = isb_pkg::ST_FULL;
            else begin
               shadow_words[n] = w;
               n++;
            end
         end
         isb_pkg::MODE_POP: begin
            if (n == 0) r.status = isb_pkg::ST_EMPTY;
            else begin
               n--;
               r.word = isb_pkg::VALUE_W'(shadow_words[n]);
            end
         end
         isb_pkg::MODE_REMOVE: begin
            if (n == 0) r.status = isb_pkg::ST_EMPTY;
            else if (int'(idx) >= n) r.status = isb_pkg::ST_RANGE;
            else begin
               r.word = isb_pkg::VALUE_W'(shadow_words[idx]);
               for (i = int'(idx); i + 1 < n; i++) shadow_words[i] = shadow_words[i + 1];
               n--;
            end
         end
         default: begin
            for (i = 0; i < n / 2; i++) begin
               swap_word = shadow_words[i];
               shadow_words[i] = shadow_words[n - 1 - i];
               shadow_words[n - 1 - i] = swap_word;
            end
         end
      endcase
      shadow_count = n;
      r.count = isb_pkg::COUNT_OUT_W'(n);
      return r;
   endfunction

   function automatic logic [isb_pkg::REQ_TDATA_W-1:0] pack_request(
         isb_pkg::mode_type m, logic [isb_pkg::VALUE_W-1:0] v,
         logic [isb_pkg::INDEX_W-1:0] idx);
      logic [isb_pkg::REQ_TDATA_W-1:0] d;
      d = '0;
      d[isb_pkg::REQ_MODE_LSB +: isb_pkg::MODE_W]   = m;
      d[isb_pkg::REQ_VALUE_LSB +: isb_pkg::VALUE_W] = v;
      d[isb_pkg::REQ_INDEX_LSB +: isb_pkg::INDEX_W] = idx;
      return d;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_request(isb_pkg::mode_type m, logic [isb_pkg::VALUE_W-1:0] v,
                               logic [isb_pkg::INDEX_W-1:0] idx, bit pin,
                               reply_type pinned);
      while (!steady_sender && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      pin_active = pin;
      pin_reply  = pinned;
      req_tvalid <= 1'b1;
      req_tdata  <= pack_request(m, v, idx);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Receiver: random stalls, one long hold-off, and a stretch with no stalls.
   initial begin : receiver
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && replies_seen >= HOLD_OFF_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= (replies_seen >= 600 && replies_seen < 800) ||
                          ($urandom_range(0, 99) >= 19);
         end
      end
   end

   // Prediction on request beats, checking on response beats, and the watchdog.
   always @(posedge clock) begin : monitor
      reply_type got;
      reply_type want;
      reply_type predicted;
      bit        progress;
      if (!reset) begin
         progress = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            progress = 1'b1;
            replies_seen++;
            got.status = isb_pkg::status_type'(
               rsp_tdata[isb_pkg::RSP_STATUS_LSB +: isb_pkg::STATUS_W]);
            got.word   = rsp_tdata[isb_pkg::RSP_WORD_LSB +: isb_pkg::VALUE_W];
            got.count  = rsp_tdata[isb_pkg::RSP_COUNT_LSB +: isb_pkg::COUNT_OUT_W];
            if (pending_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("reply beat with nothing expected: status %0d word %h count %0d",
                           got.status, got.word, got.count);
            end else begin
               want = pending_replies.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"reply %0d mismatch: expected status %0d word %h count %0d,",
                               " got status %0d word %h count %0d"},
                              replies_seen, want.status, want.word, want.count,
                              got.status, got.word, got.count);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            progress = 1'b1;
            predicted = stack_apply(
               isb_pkg::mode_type'(req_tdata[isb_pkg::REQ_MODE_LSB +: isb_pkg::MODE_W]),
               req_tdata[isb_pkg::REQ_VALUE_LSB +: isb_pkg::VALUE_W],
               req_tdata[isb_pkg::REQ_INDEX_LSB +: isb_pkg::INDEX_W]);
            pending_replies.push_back(pin_active ? pin_reply : predicted);
         end
         if (progress) idle_cycles = 0;
         else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("indexed_stack_buffer_tb: FAIL");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type                row;
      isb_pkg::mode_type           m;
      logic [isb_pkg::VALUE_W-1:0] v;
      logic [isb_pkg::INDEX_W-1:0] idx;
      int                          sent;
      int                          burst_len;
      int                          bias;
      int                          roll;
      int                          push_lim;
      int                          pop_lim;
      int                          rm_lim;
      int                          k;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      shadow_count   = 0;
      mismatch_count = 0;
      replies_seen   = 0;
      idle_cycles    = 0;
      pin_active     = 1'b0;
      pin_reply      = '0;
      steady_sender  = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         row = directed_plan[r];
         for (k = 0; k < int'(row.reps); k++)
            send_request(row.mode, row.value + isb_pkg::VALUE_W'(k), row.index,
                         row.pinned, '{row.status, row.word, row.count});
      end

      // Bursts lean toward filling, draining, or a mix so both ends are hit often.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(10, 60);
         bias      = $urandom_range(0, 2);
         case (bias)
            0:       begin push_lim = 70; pop_lim = 80; rm_lim = 90; end
            1:       begin push_lim = 15; pop_lim = 55; rm_lim = 90; end
            default: begin push_lim = 30; pop_lim = 55; rm_lim = 80; end
         endcase
         repeat (burst_len) begin
            steady_sender = (sent >= 500 && sent < 700);
            roll = $urandom_range(0, 99);
            if (roll < push_lim) m = isb_pkg::MODE_PUSH;
            else if (roll < pop_lim) m = isb_pkg::MODE_POP;
            else if (roll < rm_lim) m = isb_pkg::MODE_REMOVE;
            else m = isb_pkg::MODE_REVERSE;
            v   = $urandom;
            idx = isb_pkg::INDEX_W'($urandom_range(0, 15));
            if (m == isb_pkg::MODE_PUSH) begin
               roll = $urandom_range(0, 99);
               if (roll < 4) v = '0;
               else if (roll < 7) v = '1;
               else if (roll < 9) v = isb_pkg::VALUE_W'(1);
               else if (roll < 10) v = 32'h8000_0000;
            end else if (m == isb_pkg::MODE_REMOVE && shadow_count > 0 &&
                         $urandom_range(0, 99) < 80) begin
               idx = isb_pkg::INDEX_W'($urandom_range(0, shadow_count - 1));
            end
            send_request(m, v, idx, 1'b0, '0);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("indexed_stack_buffer_tb: PASS");
      else
         $display("indexed_stack_buffer_tb: FAIL");
      $finish;
   end

endmodule
